// ===== src/utt_pkg.sv =====
// Shared types, constants and the UTF-8 encoding function of the transcoder.
`timescale 1ns / 1ps

package utt_pkg;

   localparam int UTT_QUEUE_DEPTH = 2;
   localparam int UTT_MAX_BYTES   = 6;

   localparam logic [15:0] SURR_MASK   = 16'hfc00;
   localparam logic [15:0] SURR_HIGH   = 16'hd800;
   localparam logic [15:0] SURR_LOW    = 16'hdc00;
   localparam logic [9:0]  HALF_MASK   = 10'h3ff;
   localparam logic [20:0] PLANE_BASE  = 21'h10000;
   localparam logic [7:0]  LEAD_TWO    = 8'hc0;
   localparam logic [7:0]  LEAD_THREE  = 8'he0;
   localparam logic [7:0]  LEAD_FOUR   = 8'hf0;
   localparam logic [7:0]  CONT_MARK   = 8'h80;
   localparam logic [5:0]  CONT_MASK   = 6'h3f;

   // Bytes of one code point, first byte at index 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } enc_type;

   // One queued item: every byte it causes, first byte at index 0.
   typedef struct packed {
      logic [UTT_MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                    count;
      logic                          last;
   } job_type;

   function automatic enc_type encode_point(input logic [20:0] cp);
      enc_type enc;
      enc.bytes = '0;
      if (cp < 21'h80) begin
         enc.bytes[0] = cp[7:0];
         enc.count    = 3'd1;
      end else if (cp < 21'h800) begin
         enc.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         enc.bytes[1] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
         enc.count    = 3'd2;
      end else if (cp < PLANE_BASE) begin
         enc.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         enc.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         enc.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
         enc.count    = 3'd3;
      end else begin
         enc.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         enc.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         enc.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         enc.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
         enc.count    = 3'd4;
      end
      return enc;
   endfunction

endpackage

// ===== src/utt_req_if.sv =====
// Input channel: one UTF-16 code unit per item.
`timescale 1ns / 1ps

interface utt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== src/utt_rsp_if.sv =====
// Result channel: one UTF-8 byte per item.
`timescale 1ns / 1ps

interface utt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       string_end;

   modport source (output valid, output out_byte, output run_end, output string_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_end, input string_end,
                 output ready);
endinterface

// ===== src/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   Channel    Direction  Item                           Handshake
//   req_chan   in         code_unit[15:0], last_unit     valid/ready
//   rsp_chan   out        out_byte[7:0], run_end,        valid/ready
//                         string_end
//
// The output sends one byte per cycle while it is ready. An item causes one
// to three bytes for a unit of the basic plane, four for a surrogate pair,
// up to six when a held surrogate is flushed, none while a high surrogate
// is held. The output byte stage sets this rate.
// A unit's first byte passes a queue slot, then the back end's job register.
// Reset is synchronous and clears the held surrogate, the queue and the output.
// The front end, the queue and the back end stall independently: units keep
// being accepted while the queue has room, even when the output is stalled.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   utt_req_if.sink  req_chan,
   utt_rsp_if.source rsp_chan
);
   import utt_pkg::*;

   // Front end to queue.
   logic    push_valid, push_ready;
   job_type push_job;

   // Queue to back end.
   logic    pop_valid, pop_ready;
   job_type pop_job;

   // The front end tracks a pending high surrogate and builds the complete
   // byte sequence of each unit, including any flushed surrogate ahead of it.
   utt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .code_unit  (req_chan.code_unit),
      .last_unit  (req_chan.last_unit),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // The queue decouples unit acceptance from byte output.
   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The back end walks through each job and flags the last byte of the item
   // and the last byte of the string.
   utt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.out_byte),
      .run_end    (rsp_chan.run_end),
      .string_end (rsp_chan.string_end)
   );

endmodule

// ===== src/utt_front.sv =====
// Front end: pairs surrogates and turns each code unit into its UTF-8 bytes.
`timescale 1ns / 1ps

module utt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [15:0]      code_unit,
   input  logic             last_unit,
   output logic             push_valid,
   input  logic             push_ready,
   output utt_pkg::job_type push_job
);
   import utt_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       is_low, is_high, pair, flush, main_en, accept;
   logic [20:0] main_cp;
   enc_type    main_enc, flush_enc;
   logic [2:0] main_count;

   assign is_low  = (code_unit & SURR_MASK) == SURR_LOW;
   assign is_high = (code_unit & SURR_MASK) == SURR_HIGH;
   assign pair    = held_valid_ff && is_low;
   assign flush   = held_valid_ff && !is_low;
   assign main_en = pair || !(is_high && !last_unit);
   assign main_cp = pair ? PLANE_BASE + {1'b0, held_bits_ff, code_unit[9:0] & HALF_MASK}
                         : {5'b00000, code_unit};

   always_comb begin
      main_enc   = encode_point(main_cp);
      flush_enc  = encode_point({5'b00000, SURR_HIGH[15:10], held_bits_ff});
      main_count = main_en ? main_enc.count : 3'd0;
      push_job       = '0;
      push_job.last  = last_unit;
      if (flush) begin
         push_job.bytes[2:0] = flush_enc.bytes[2:0];
         push_job.bytes[5:3] = main_enc.bytes[2:0];
         push_job.count      = 3'd3 + main_count;
      end else begin
         push_job.bytes[3:0] = main_enc.bytes;
         push_job.count      = main_count;
      end
   end

   // Items that cause no byte (a held high surrogate) never enter the queue.
   assign in_ready   = push_ready;
   assign push_valid = in_valid && (push_job.count != 3'd0);
   assign accept     = in_valid && in_ready;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         if (!pair && is_high && !last_unit) begin
            held_valid_in = 1'b1;
            held_bits_in  = code_unit[9:0];
         end else begin
            held_valid_in = 1'b0;
            held_bits_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

// ===== src/utt_queue.sv =====
// Short first-in first-out queue of byte jobs between front and back end.
`timescale 1ns / 1ps

module utt_queue #(
   parameter int DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  utt_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output utt_pkg::job_type pop_job
);
   import utt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = fill_ff != CNT_FULL;
   assign pop_valid  = fill_ff != '0;
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/utt_back.sv =====
// Back end: sends the bytes of one job out, one byte per cycle unless stalled.
`timescale 1ns / 1ps

module utt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  utt_pkg::job_type pop_job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             run_end,
   output logic             string_end
);
   import utt_pkg::*;

   job_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       load;

   assign out_valid  = busy_ff;
   assign out_byte   = cur_ff.bytes[idx_ff];
   assign run_end    = idx_ff == (cur_ff.count - 3'd1);
   assign string_end = run_end && cur_ff.last;

   // A new job is taken when idle or as the last byte of the current one leaves.
   assign load      = !busy_ff || (out_ready && run_end);
   assign pop_ready = load;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = pop_valid;
         cur_in  = pop_job;
         idx_in  = '0;
      end else if (out_ready) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== src/utt_checker.sv =====
// Port-level checks of the transcoder, bound to the top level.
`timescale 1ns / 1ps

module utt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_end,
   input logic       rsp_string_end
);

   // A stalled byte holds its value and flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                && $stable(rsp_run_end) && $stable(rsp_string_end))
      else $error("stalled output byte changed");

   // The end of a string is always the end of an item's bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

   // A lead byte of a multi-byte sequence never closes a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte[7:6] == 2'b11 |-> !rsp_run_end)
      else $error("run ends on a lead byte");

   // Nothing is offered straight out of reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_utt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_run_end    (rsp_chan.run_end),
   .rsp_string_end (rsp_chan.string_end)
);
